FILE: rtl/iterative_sigma_clip_top_macros.svh
// Assertion macros for the sigma clipping block
`ifndef ITERATIVE_SIGMA_CLIP_TOP_MACROS_SVH
`define ITERATIVE_SIGMA_CLIP_TOP_MACROS_SVH
// implication checked every clock outside reset
`define ISC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("isc assertion failed");
// next-cycle implication
`define ISC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("isc assertion failed");
`endif

FILE: rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the sigma clipping block.
// ----------------------------------------------------------------------------
package isc_pkg;
    localparam int MAX_PIXELS = 1024;
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int CW = AW + 1;
    localparam int MIN_KEEP = 10;
    localparam int MIN_DETECT = 3;
    localparam int FIRST_GOOD = 100;
    localparam logic signed [31:0] LOW_LIMIT = -32'sd1310720;
    localparam logic [31:0] SMALL_MAG = 32'd6;
    localparam logic [47:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;

    localparam logic [1:0] REG_NSIGMA = 2'd0;
    localparam logic [1:0] REG_MAXC = 2'd1;
    localparam logic [1:0] REG_USEEXP = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] pixel_value;
        logic [31:0] exposure_value;
        logic        prior_reject;
        logic        last_pixel;
        logic [9:0]  read_index;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [47:0] clipped_sum;
        logic [10:0] good_count;
        logic        reject_flag;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_P1, S_MEAN, S_P2, S_SQRT, S_THR, S_P3, S_NEXT, S_DONE
    } t_state;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;
endpackage

FILE: rtl/isc_div.sv
// ----------------------------------------------------------------------------
// isc_div
// Radix-2 restoring divider, 64 by 64, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module isc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isc_pkg::t_div_req i_req,
    output isc_pkg::t_div_rsp o_rsp
);
    import isc_pkg::*;
    logic [63:0] r_rem, r_quo, r_den, n_rem_sh;
    logic [64:0] diff;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;

    assign n_rem_sh = {r_rem[62:0], r_quo[63]};
    assign diff = {r_rem, r_quo[63]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!diff[64]) begin
                    r_rem <= diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

FILE: rtl/iterative_sigma_clip_top.sv
// ----------------------------------------------------------------------------
// iterative_sigma_clip_top
// Stores an annulus of pixels and runs iterative sigma clipping over it.
// ----------------------------------------------------------------------------
// channel  | direction | handshake
// command  | in        | i_start high while o_busy low
// result   | out       | o_strobe, one cycle
// config   | in        | APB psel/penable/pwrite/pready
// A load other than the last pixel never raises busy; a readback holds busy
// through S_RD and S_DONE and strobes in the cycle after. On the last pixel
// each pass walks the store in S_P1, then in S_P2 and S_P3 if detections
// suffice; with exposure on, each rate uses the shared 64-step divider, as
// do the mean and the variance quotient; the square root then runs 32 steps.
// Reset is synchronous. No memory clearing pass. The receiver cannot stall.
`include "iterative_sigma_clip_top_macros.svh"
module iterative_sigma_clip_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  isc_pkg::t_in     i_data,
    output logic             o_strobe,
    output isc_pkg::t_out    o_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import isc_pkg::*;

    logic [15:0] r_nsig;
    logic [30:0] r_maxc;
    logic        r_useexp;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsig <= 16'd768;
            r_maxc <= 31'h7FFF_FFFF;
            r_useexp <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_NSIGMA: r_nsig <= pwdata[15:0];
                REG_MAXC:   r_maxc <= pwdata[30:0];
                REG_USEEXP: r_useexp <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NSIGMA: prdata = {16'd0, r_nsig};
            REG_MAXC:   prdata = {1'b0, r_maxc};
            REG_USEEXP: prdata = {31'd0, r_useexp};
            default:    prdata = '0;
        endcase
    end

    // stores
    logic [31:0] pix_mem [MAX_PIXELS];
    logic [31:0] exp_mem [MAX_PIXELS];
    logic        rej_mem [MAX_PIXELS];
    logic [31:0] r_pix, r_exp;
    logic        r_rej;

    t_state r_st, n_st;
    logic [CW-1:0] r_cnt, r_i;
    logic [CW-1:0] r_nrej, r_ngood, r_ndet;
    logic [47:0] r_ct;
    logic signed [63:0] r_msum, r_mean;
    logic [63:0] r_s;
    logic [55:0] r_thr;
    logic [1:0]  r_ph;    // 0 read issue, 1 data valid, 2 wait divider
    logic [63:0] r_rate;
    logic        r_rate_ok;
    logic        r_first;
    logic        r_rb;
    logic        r_rbflag;
    logic [63:0] r_sq_v, r_sq_r, r_sq_b;
    logic [5:0]  r_sq_n;
    logic        r_div_go;
    logic [63:0] r_dnum, r_dden;
    logic        r_negq;

    t_div_req dreq;
    t_div_rsp drsp;
    assign dreq.start = r_div_go;
    assign dreq.num = r_dnum;
    assign dreq.den = r_dden;
    isc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    logic accept;
    assign accept = i_start & ~o_busy;
    assign o_busy = (r_st != S_IDLE);

    // pixel fields of the read entry
    logic signed [31:0] pix;
    logic [31:0] pmag;
    logic rej_now, rej_p1;
    assign pix = r_pix;
    assign pmag = pix[31] ? (32'd0 - r_pix) : r_pix;
    assign rej_p1 = r_first && ((r_useexp && r_exp == 32'd0)
        || (pix > $signed({1'b0, r_maxc})) || (pix < LOW_LIMIT));

    logic signed [63:0] dev;
    logic [63:0] adev, u64, sq;
    logic [31:0] u;
    assign dev = $signed(r_rate) - r_mean;
    assign adev = dev[63] ? (64'd0 - dev) : dev;
    assign u64 = adev >> 16;
    assign u = (u64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u64[31:0];
    assign sq = {32'd0, u} * {32'd0, u};

    logic [63:0] qsat;
    assign qsat = (drsp.quo > {16'd0, RATE_MAX}) ? {16'd0, RATE_MAX} : drsp.quo;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (accept) n_st = i_data.mode ? S_RD :
                (i_data.last_pixel ? S_P1 : S_IDLE);
            S_RD: n_st = S_DONE;
            S_P1: if (r_i == r_cnt && r_ph == 2'd0) n_st = S_MEAN;
            S_MEAN: begin
                if (r_ndet <= CW'(MIN_DETECT)) n_st = S_NEXT;
                else if (drsp.done) n_st = S_P2;
            end
            S_P2: if (r_i == r_cnt && r_ph == 2'd0) n_st = S_SQRT;
            S_SQRT: if (r_sq_n == 6'd33) n_st = S_THR;
            S_THR: n_st = S_P3;
            S_P3: if (r_i == r_cnt && r_ph == 2'd0) n_st = S_NEXT;
            S_NEXT: n_st = (r_nrej != '0 && r_ngood > CW'(MIN_KEEP)) ? S_P1 : S_IDLE;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // walk: r_ph 0 = issue read of r_i, 1 = data present, 2 = wait divider
    always_ff @(posedge i_clk) begin
        if (accept && !i_data.mode && r_cnt < CW'(MAX_PIXELS)) begin
            pix_mem[r_cnt[AW-1:0]] <= i_data.pixel_value;
            exp_mem[r_cnt[AW-1:0]] <= i_data.exposure_value;
            rej_mem[r_cnt[AW-1:0]] <= i_data.prior_reject;
        end else if (r_ph == 2'd1 && (r_st == S_P1 || r_st == S_P3) && r_rate_ok
                     && !r_rej && (rej_now || (r_st == S_P1 && rej_p1))) begin
            rej_mem[r_i[AW-1:0] - AW'(1)] <= 1'b1;
        end
        // hold the entry while its rate is formed
        if (r_ph == 2'd0) begin
            r_pix <= pix_mem[r_i[AW-1:0]];
            r_exp <= exp_mem[r_i[AW-1:0]];
            r_rej <= rej_mem[r_i[AW-1:0]];
        end
        if (accept) r_rbflag <= rej_mem[i_data.read_index[AW-1:0]];
    end

    // pass 3 reject test
    assign rej_now = (r_st == S_P3) && (pmag > SMALL_MAG) && (adev > {8'd0, r_thr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_i <= '0;
            r_ph <= 2'd0;
            r_div_go <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            r_div_go <= 1'b0;
            o_strobe <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    r_i <= '0;
                    r_ph <= 2'd0;
                    r_rate_ok <= 1'b0;
                    r_msum <= '0; r_ndet <= '0; r_nrej <= '0; r_ngood <= '0;
                    r_rb <= accept & i_data.mode
                        & ({1'b0, i_data.read_index} < CW'(MAX_PIXELS));
                    if (accept && !i_data.mode && r_cnt < CW'(MAX_PIXELS))
                        r_cnt <= r_cnt + CW'(1);
                    if (accept) r_first <= 1'b1;
                end
                S_RD: ;
                S_P1, S_P2, S_P3: begin
                    case (r_ph)
                        2'd0: begin
                            if (r_i != r_cnt) begin
                                r_ph <= 2'd1;
                                r_i <= r_i + CW'(1);
                                r_rate_ok <= 1'b0;
                            end
                        end
                        2'd1: begin
                            if (!r_rate_ok) begin
                                if (!r_useexp) begin
                                    r_rate <= {{16{r_pix[31]}}, r_pix, 16'd0};
                                    r_rate_ok <= 1'b1;
                                end else if (r_exp == 32'd0) begin
                                    r_rate <= '0;
                                    r_rate_ok <= 1'b1;
                                end else begin
                                    r_dnum <= {pmag, 32'd0};
                                    r_dden <= {32'd0, r_exp};
                                    r_negq <= r_pix[31];
                                    r_div_go <= 1'b1;
                                    r_ph <= 2'd2;
                                end
                            end else begin
                                r_ph <= 2'd0;
                                if (r_st == S_P1) begin
                                    if (!r_rej) begin
                                        if (rej_p1) r_nrej <= r_nrej + CW'(1);
                                        else begin
                                            r_msum <= r_msum + $signed(r_rate);
                                            if (r_pix != 32'd0) r_ndet <= r_ndet + CW'(1);
                                            r_ngood <= r_ngood + CW'(1);
                                        end
                                    end
                                end else if (r_st == S_P2) begin
                                    if (!r_rej && r_rate != 64'd0)
                                        r_s <= (r_s > ~sq) ? '1 : r_s + sq;
                                end else if (!r_rej && pmag > SMALL_MAG) begin
                                    if (rej_now) r_nrej <= r_nrej + CW'(1);
                                    else r_ct <= r_ct + {{16{r_pix[31]}}, r_pix};
                                end
                            end
                        end
                        default: begin
                            if (drsp.done) begin
                                r_rate <= r_negq ? (64'd0 - qsat) : qsat;
                                r_rate_ok <= 1'b1;
                                r_ph <= 2'd1;
                            end
                        end
                    endcase
                    if (n_st != r_st) begin
                        r_i <= '0;
                        r_ph <= 2'd0;
                    end
                    if (r_st == S_P1 && n_st == S_MEAN) begin
                        r_first <= 1'b0;
                        r_dnum <= r_msum[63] ? 64'd0 - r_msum : r_msum;
                        r_dden <= {{(64-CW){1'b0}}, r_ndet};
                        r_negq <= r_msum[63];
                        r_div_go <= (r_ndet > CW'(MIN_DETECT));
                        r_s <= '0;
                        r_ct <= '0;
                    end
                    if (r_st == S_P2 && n_st == S_SQRT) begin
                        r_dnum <= r_s;
                        r_dden <= {{(64-CW){1'b0}}, r_ndet - CW'(1)};
                        r_div_go <= 1'b1;
                        r_sq_n <= '0;
                    end
                end
                S_MEAN: begin
                    if (r_ndet <= CW'(MIN_DETECT)) begin
                        r_ct <= '0;
                    end else if (drsp.done) begin
                        r_mean <= r_negq ? $signed(64'd0 - drsp.quo) : $signed(drsp.quo);
                    end
                end
                S_SQRT: begin
                    if (r_sq_n == 6'd0) begin
                        if (drsp.done) begin
                            r_sq_v <= drsp.quo;
                            r_sq_r <= '0;
                            r_sq_b <= 64'h4000_0000_0000_0000;
                            r_sq_n <= 6'd1;
                        end
                    end else if (r_sq_n != 6'd33) begin
                        if (r_sq_v >= r_sq_r + r_sq_b) begin
                            r_sq_v <= r_sq_v - (r_sq_r + r_sq_b);
                            r_sq_r <= (r_sq_r >> 1) + r_sq_b;
                        end else begin
                            r_sq_r <= r_sq_r >> 1;
                        end
                        r_sq_b <= r_sq_b >> 2;
                        r_sq_n <= r_sq_n + 6'd1;
                    end
                end
                S_THR: begin
                    r_thr <= {({32'd0, r_nsig} * {16'd0, r_sq_r[31:0]}), 8'd0};
                    r_ct <= '0;
                end
                S_NEXT: begin
                    r_first <= 1'b0;
                    if (n_st == S_P1) begin
                        r_nrej <= '0; r_ngood <= '0; r_msum <= '0; r_ndet <= '0;
                    end else begin
                        o_strobe <= 1'b1;
                        o_data.result_kind <= 1'b0;
                        o_data.clipped_sum <= r_ct;
                        o_data.good_count <= (r_cnt == '0) ? 11'd0 : 11'(r_ngood);
                        o_data.reject_flag <= 1'b0;
                        r_cnt <= '0;
                    end
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    o_data.result_kind <= 1'b1;
                    o_data.clipped_sum <= '0;
                    o_data.good_count <= '0;
                    o_data.reject_flag <= r_rb & r_rbflag;
                end
                default: ;
            endcase
        end
    end

    `ISC_ASSERT_NEXT(a_no_start_busy, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ISC_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_PIXELS))
    `ISC_ASSERT_IMPL(a_strobe_done, i_clk, i_rst_n, o_strobe, r_st == S_IDLE)
endmodule

FILE: sim/iterative_sigma_clip_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iterative_sigma_clip_top_tb
// Self-checking bench for the iterative sigma clipping block.
// Loads annuli of pixels and reads back reject marks through the command
// port. Register settings are changed over APB between phases. Each
// summary and readback is checked against a behavioral clipping model
// kept in the bench.
// ----------------------------------------------------------------------------
module iterative_sigma_clip_top_tb;
    import isc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in         i_data;
    logic        o_strobe;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iterative_sigma_clip_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_data(i_data), .o_strobe(o_strobe), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the block's state and registers
    logic [31:0] pix_mem [0:MAX_PIXELS-1];
    logic [31:0] exp_mem [0:MAX_PIXELS-1];
    bit          rej_mem [0:MAX_PIXELS-1];
    int          pix_cnt;
    int          loaded_hi;
    logic [15:0] cfg_nsigma;
    logic [30:0] cfg_maxc;
    logic        cfg_useexp;

    t_out expected_results[$];
    int   errors;
    int   n_items;
    int   n_annuli;
    int   n_reads;
    int   n_checked;
    int   idle_cycles;
    int   burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // clipping model
    // ------------------------------------------------------------------
    function automatic longint unsigned mag(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint rate_of(input int i);
        longint pix;
        longint unsigned e;
        longint unsigned q;
        pix = longint'(signed'(pix_mem[i]));
        if (!cfg_useexp) return pix * 65536;
        e = exp_mem[i];
        if (e == 0) return 0;
        q = (mag(pix) << 32) / e;
        if (q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
        return pix < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic clip_annulus(output longint sum_out, output int good_out);
        int n;
        int nrej;
        int ngood;
        int ndet;
        longint ct;
        longint msum;
        longint mean;
        longint pix;
        longint r;
        longint unsigned s;
        longint unsigned sq;
        longint unsigned u;
        longint unsigned sigma;
        longint unsigned thr;
        n = pix_cnt;
        nrej = 1;
        ngood = FIRST_GOOD;
        ct = 0;
        good_out = 0;
        while (nrej > 0 && ngood > MIN_KEEP) begin
            ct = 0; nrej = 0; ngood = 0; msum = 0; ndet = 0;
            for (int i = 0; i < n; i++) begin
                pix = longint'(signed'(pix_mem[i]));
                if (cfg_useexp && !rej_mem[i] && exp_mem[i] == 0) begin
                    rej_mem[i] = 1; nrej++;
                end
                if (!rej_mem[i] && (pix > longint'(cfg_maxc)
                        || pix < longint'(LOW_LIMIT))) begin
                    rej_mem[i] = 1; nrej++;
                end
                if (!rej_mem[i]) begin
                    msum += rate_of(i);
                    if (pix != 0) ndet++;
                    ngood++;
                end
            end
            if (ndet > MIN_DETECT) begin
                mean = msum / longint'(ndet);
                s = 0;
                for (int i = 0; i < n; i++) begin
                    if (rej_mem[i]) continue;
                    r = rate_of(i);
                    if (r == 0) continue;
                    u = mag(r - mean) >> 16;
                    if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
                    sq = u * u;
                    s = (s > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : s + sq;
                end
                sigma = int_sqrt(s / longint'(ndet - 1));
                thr = (longint'(cfg_nsigma) * sigma) << 8;
                for (int i = 0; i < n; i++) begin
                    if (rej_mem[i]) continue;
                    pix = longint'(signed'(pix_mem[i]));
                    if (mag(pix) > SMALL_MAG) begin
                        if (mag(rate_of(i) - mean) > thr) begin
                            rej_mem[i] = 1; nrej++;
                        end else begin
                            ct += pix;
                        end
                    end
                end
            end
            good_out = ngood;
        end
        if (n == 0) good_out = 0;
        sum_out = ct;
    endtask

    task automatic predict(input t_in it);
        t_out res;
        longint sum;
        int good;
        res = '0;
        if (it.mode) begin
            res.result_kind = 1'b1;
            res.reject_flag = (it.read_index < MAX_PIXELS) ? rej_mem[it.read_index] : 1'b0;
            expected_results.push_back(res);
            n_reads++;
            return;
        end
        if (pix_cnt < MAX_PIXELS) begin
            pix_mem[pix_cnt] = it.pixel_value;
            exp_mem[pix_cnt] = it.exposure_value;
            rej_mem[pix_cnt] = it.prior_reject;
            pix_cnt++;
            if (pix_cnt > loaded_hi) loaded_hi = pix_cnt;
        end
        if (it.last_pixel) begin
            clip_annulus(sum, good);
            pix_cnt = 0;
            if (good > 2047) good = 2047;
            res.clipped_sum = sum[47:0];
            res.good_count = good[10:0];
            expected_results.push_back(res);
            n_annuli++;
        end
    endtask

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic send_item(input t_in it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(3) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict(it);
        n_items++;
        burst_left--;
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_NSIGMA: cfg_nsigma = val[15:0];
            REG_MAXC:   cfg_maxc = val[30:0];
            REG_USEEXP: cfg_useexp = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] ns, input logic [30:0] mc, input logic ue);
        reg_write(REG_NSIGMA, {16'd0, ns});
        reg_write(REG_MAXC, {1'b0, mc});
        reg_write(REG_USEEXP, {31'd0, ue});
    endtask

    function automatic t_in load_item(input logic [31:0] pv, input logic [31:0] ev,
                                      input logic pr, input logic last);
        t_in it;
        it = '0;
        it.pixel_value = pv;
        it.exposure_value = ev;
        it.prior_reject = pr;
        it.last_pixel = last;
        it.read_index = 10'($urandom);
        return it;
    endfunction

    function automatic t_in read_item(input int idx);
        t_in it;
        it = t_in'({$urandom, $urandom, $urandom});
        it.mode = 1'b1;
        it.read_index = idx[9:0];
        return it;
    endfunction

    // pixel with a mix of clustered values, outliers and edge values
    function automatic t_in random_pixel(input int base, input int spread, input logic last);
        int k;
        logic [31:0] pv;
        logic [31:0] ev;
        k = $urandom_range(99);
        if (k < 68) pv = base + $signed($urandom_range(0, 2 * spread)) - spread;
        else if (k < 73) pv = 0;
        else if (k < 78) pv = $signed($urandom_range(0, 12)) - 6;
        else if (k < 83) pv = LOW_LIMIT - $signed($urandom_range(0, 3));
        else if (k < 88) pv = 32'h7FFF_FFFF - $urandom_range(0, 100000);
        else if (k < 93) pv = $urandom;
        else pv = base + ($urandom_range(1) ? 1 : -1) * spread * $signed($urandom_range(5, 40));
        k = $urandom_range(99);
        if (k < 80) ev = 32'd65536 + $urandom_range(0, 40000) - 20000;
        else if (k < 88) ev = 0;
        else ev = $urandom;
        return load_item(pv, ev, $urandom_range(9) == 0, last);
    endfunction

    task automatic maybe_read();
        if (loaded_hi > 0 && $urandom_range(99) < 15)
            send_item(read_item($urandom_range(0, loaded_hi - 1)));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_item(load_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_item(load_item(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0));
        send_item(load_item(LOW_LIMIT, 32'h0001_0000, 1'b0, 1'b0));
        send_item(load_item(LOW_LIMIT - 1, 32'h0001_0000, 1'b0, 1'b0));
        send_item(load_item(32'd6, 32'h0001_0000, 1'b0, 1'b0));
        send_item(load_item(-32'sd6, 32'h0001_0000, 1'b0, 1'b0));
        send_item(load_item(32'd7, 32'h0001_0000, 1'b1, 1'b0));
        send_item(load_item(32'd0, 32'h0001_0000, 1'b0, 1'b0));
        for (int i = 0; i < 8; i++)
            send_item(load_item(32'h0010_0000 + i * 32'h100, 32'h0001_0000, 1'b0, 1'b0));
        send_item(load_item(32'h0100_0000, 32'h0001_0000, 1'b0, 1'b1));
        for (int i = 0; i < 4; i++) send_item(read_item(i * 5));
        // few detections: three nonzero pixels only
        send_item(load_item(32'h0001_0000, 32'h1, 1'b0, 1'b0));
        send_item(load_item(32'h0002_0000, 32'h1, 1'b0, 1'b0));
        send_item(load_item(32'd0, 32'h1, 1'b0, 1'b0));
        send_item(load_item(32'h0003_0000, 32'h1, 1'b0, 1'b1));
        wait_idle();
        set_config(16'hFFFF, 31'd0, 1'b1);
        for (int i = 0; i < 14; i++)
            send_item(random_pixel(-32'sd50000, 3000, i == 13));
        wait_idle();
    endtask

    task automatic test_store_full();
        set_config(16'd768, 31'h7FFF_FFFF, 1'b0);
        for (int i = 0; i <= MAX_PIXELS; i++)
            send_item(random_pixel(32'h0020_0000, 20000, i == MAX_PIXELS));
        for (int i = 0; i < 6; i++)
            send_item(read_item(i == 0 ? MAX_PIXELS - 1 : $urandom_range(0, MAX_PIXELS - 1)));
        wait_idle();
    endtask

    task automatic test_random();
        logic [15:0] ns;
        logic [30:0] mc;
        int base;
        int spread;
        int size;
        int sent;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: ns = 16'd768;
                1: ns = 16'd0;
                2: ns = 16'hFFFF;
                3: ns = 16'd256 + $urandom_range(0, 512);
                default: ns = 16'($urandom);
            endcase
            case (ph % 3)
                0: mc = 31'h7FFF_FFFF;
                1: mc = 31'($urandom_range(0, 32'h0100_0000));
                default: mc = 31'd0;
            endcase
            set_config(ns, mc, ph[0]);
            sent = 0;
            while (sent < 80) begin
                base = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0100_0000;
                spread = $urandom_range(1, 1 << $urandom_range(4, 20));
                case ($urandom_range(19))
                    0: size = $urandom_range(1, 10);
                    1: size = cfg_useexp ? $urandom_range(21, 30) : $urandom_range(40, 80);
                    default: size = cfg_useexp ? $urandom_range(11, 20) : $urandom_range(11, 30);
                endcase
                for (int i = 0; i < size; i++) begin
                    maybe_read();
                    send_item(random_pixel(base, spread, i == size - 1));
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // result check and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                t_out e;
                e = expected_results.pop_front();
                n_checked++;
                if (o_data.result_kind !== e.result_kind) begin
                    $error("result_kind exp %0d got %0d", e.result_kind, o_data.result_kind);
                    errors++;
                end
                if (o_data.clipped_sum !== e.clipped_sum) begin
                    $error("clipped_sum exp %h got %h", e.clipped_sum, o_data.clipped_sum);
                    errors++;
                end
                if (o_data.good_count !== e.good_count) begin
                    $error("good_count exp %0d got %0d", e.good_count, o_data.good_count);
                    errors++;
                end
                if (o_data.reject_flag !== e.reject_flag) begin
                    $error("reject_flag exp %0d got %0d", e.reject_flag, o_data.reject_flag);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        n_items = 0;
        n_annuli = 0;
        n_reads = 0;
        n_checked = 0;
        idle_cycles = 0;
        burst_left = 0;
        pix_cnt = 0;
        loaded_hi = 0;
        cfg_nsigma = 16'd768;
        cfg_maxc = 31'h7FFF_FFFF;
        cfg_useexp = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_random();
        $display("covered %0d commands: %0d annuli clipped, %0d mark readbacks, %0d results checked",
                 n_items, n_annuli, n_reads, n_checked);
        $display("register settings swept across threshold, saturation and exposure extremes");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
